>>> rtl/psl_pkg.sv
// Shared types and constants for the pedal scale and low-pass block.
package psl_pkg;

  localparam int MV_W     = 13;  // millivolt fields and calibration registers
  localparam int PM_W     = 10;  // per mille values, 0..1000
  localparam int Q_W      = 10;  // quotient bits of the scaling divider
  localparam int NUM_W    = 23;  // 1000 * (v - min) fits in 23 bits
  localparam int NUM_CFG  = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [PM_W-1:0] FULL_SCALE = 10'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAS_FRONT_MIN   = 3'd0,
    REG_GAS_FRONT_MAX   = 3'd1,
    REG_GAS_REAR_MIN    = 3'd2,
    REG_GAS_REAR_MAX    = 3'd3,
    REG_BRAKE_FRONT_MIN = 3'd4,
    REG_BRAKE_FRONT_MAX = 3'd5,
    REG_BRAKE_REAR_MIN  = 3'd6,
    REG_BRAKE_REAR_MAX  = 3'd7
  } cfg_reg_e;

  localparam logic [MV_W-1:0] CFG_RESET [NUM_CFG] = '{
    13'd535, 13'd4532, 13'd535, 13'd4518, 13'd538, 13'd4535, 13'd532, 13'd4525
  };

  typedef struct packed {
    logic [MV_W-1:0] gas_front_mv;
    logic [MV_W-1:0] gas_rear_mv;
    logic [MV_W-1:0] brake_front_mv;
    logic [MV_W-1:0] brake_rear_mv;
    logic            seat_is_front;
  } psl_in_t;

  typedef struct packed {
    logic [PM_W-1:0] filtered_pedal;
    logic [PM_W-1:0] brake_permille;
  } psl_out_t;

  // Status a scaling lane reports to the merge stage.
  typedef struct packed {
    logic            busy;
    logic [PM_W-1:0] permille;
  } psl_lane_stat_t;

endpackage

>>> rtl/pedal_scale_and_lowpass.sv
// Pedal scaling and low-pass filter: top level with calibration registers and control.
//
// Each input word carries the A-channel voltages of both seats' gas and brake
// pedals plus a seat flag. Two lanes run side by side, one scaling the selected
// gas voltage and one the selected brake voltage to per mille of its calibrated
// span; each lane owns a bit-serial divider that produces one quotient bit per
// cycle. The merge stage forms gas minus brake, runs it through a first-order
// IIR low-pass with a Q0.16 coefficient (one multiply, then add, truncate and
// clamp to 0..1000) and keeps the result as filter state. Each input word yields
// exactly one output word. When a lane divides, its 10 divider steps dominate the
// time from one acceptance to the next; no division runs when both voltages fall
// outside their spans or a span is zero. The output register decouples the sides:
// a new word is taken while an earlier result still waits. The user must write the
// calibration registers through cfg_we/cfg_index/cfg_wdata only while the block is
// idle; the block does not enforce it. Writes take effect at once, with no read-back.
module pedal_scale_and_lowpass
  import psl_pkg::*;
#(
  parameter int unsigned FILTER_COEFF_Q16 = 63155
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  psl_in_t              in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output psl_out_t             out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MV_W-1:0]      cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCALE = 4'b0010,
    ST_FILT  = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

  state_t          state;
  state_t          state_next;
  logic [MV_W-1:0] cfg_regs [NUM_CFG];

  logic            in_acc;
  logic            out_free;
  logic            filt_start;
  logic            filt_done;
  logic            load_out;
  logic [PM_W-1:0] filt_value;

  logic [MV_W-1:0] gas_v, gas_lo, gas_hi;
  logic [MV_W-1:0] brk_v, brk_lo, brk_hi;
  psl_lane_stat_t  gas_stat;
  psl_lane_stat_t  brk_stat;

  // Calibration registers; the host must write them only while the block is idle (not enforced)
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_regs[i] <= CFG_RESET[i];
      end
    end else if (cfg_we) begin
      cfg_regs[cfg_index] <= cfg_wdata;
    end
  end

  // Route the selected seat's voltages and calibration into the lanes
  always_comb begin
    if (in_word.seat_is_front) begin
      gas_v  = in_word.gas_front_mv;
      gas_lo = cfg_regs[REG_GAS_FRONT_MIN];
      gas_hi = cfg_regs[REG_GAS_FRONT_MAX];
      brk_v  = in_word.brake_front_mv;
      brk_lo = cfg_regs[REG_BRAKE_FRONT_MIN];
      brk_hi = cfg_regs[REG_BRAKE_FRONT_MAX];
    end else begin
      gas_v  = in_word.gas_rear_mv;
      gas_lo = cfg_regs[REG_GAS_REAR_MIN];
      gas_hi = cfg_regs[REG_GAS_REAR_MAX];
      brk_v  = in_word.brake_rear_mv;
      brk_lo = cfg_regs[REG_BRAKE_REAR_MIN];
      brk_hi = cfg_regs[REG_BRAKE_REAR_MAX];
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  psl_scale_lane u_gas_lane (
    .clk   (clk),
    .rst   (rst),
    .start (in_acc),
    .v     (gas_v),
    .lo    (gas_lo),
    .hi    (gas_hi),
    .stat  (gas_stat)
  );

  psl_scale_lane u_brake_lane (
    .clk   (clk),
    .rst   (rst),
    .start (in_acc),
    .v     (brk_v),
    .lo    (brk_lo),
    .hi    (brk_hi),
    .stat  (brk_stat)
  );

  psl_filter #(
    .FILTER_COEFF_Q16 (FILTER_COEFF_Q16)
  ) u_filter (
    .clk      (clk),
    .rst      (rst),
    .start    (filt_start),
    .gas_pm   (gas_stat.permille),
    .brake_pm (brk_stat.permille),
    .done     (filt_done),
    .value    (filt_value)
  );

  // Sequence one word: scale in both lanes, filter, then hand to the output register
  always_comb begin
    state_next = state;
    filt_start = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (!gas_stat.busy && !brk_stat.busy) begin
          filt_start = 1'b1;
          state_next = ST_FILT;
        end
      end
      ST_FILT: begin
        if (filt_done) begin
          if (out_free) begin
            load_out   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Lanes and filter hold their results until the next start, so load from them directly
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word.filtered_pedal <= filt_value;
      out_word.brake_permille <= brk_stat.permille;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_lanes_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!gas_stat.busy && !brk_stat.busy))
    else $error("scaling lane busy while idle");

  a_accept_starts_scale: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == ST_SCALE))
    else $error("accepted word did not enter scaling");

  a_filtered_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.filtered_pedal <= FULL_SCALE))
    else $error("filtered pedal above full scale");

  a_brake_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.brake_permille <= FULL_SCALE))
    else $error("brake per mille above full scale");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("output register overwritten before it was taken");
`endif

endmodule

>>> rtl/psl_scale_lane.sv
// One scaling lane: clamp tests and a bit-serial divider for 1000*(v-min)/span.
module psl_scale_lane
  import psl_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [MV_W-1:0] v,
  input  logic [MV_W-1:0] lo,
  input  logic [MV_W-1:0] hi,
  output psl_lane_stat_t  stat
);

  localparam int CNT_W = $clog2(Q_W);

  logic              busy;
  logic [PM_W-1:0]   permille;
  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dsh;
  logic [Q_W-1:0]    quot;
  logic [CNT_W-1:0]  cnt;

  logic [MV_W-1:0]   span;
  logic [MV_W-1:0]   v_off;
  logic [NUM_W-1:0]  num;
  logic              ge;

  assign span  = hi - lo;
  assign v_off = v - lo;
  assign num   = NUM_W'(v_off) * NUM_W'(FULL_SCALE);
  assign ge    = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      // Above max wins over below min, so inverted calibration reads full scale above max, zero below
      if (v > hi) begin
        permille <= FULL_SCALE;
        busy     <= 1'b0;
      end else if ((v < lo) || (span == '0)) begin
        permille <= '0;
        busy     <= 1'b0;
      end else begin
        busy <= 1'b1;
        rem  <= num;
        dsh  <= NUM_W'(span) << (Q_W - 1);
        cnt  <= CNT_W'(Q_W - 1);
        quot <= '0;
      end
    end else if (busy) begin
      // One quotient bit per cycle, most significant first
      quot <= {quot[Q_W-2:0], ge};
      rem  <= ge ? (rem - dsh) : rem;
      dsh  <= dsh >> 1;
      cnt  <= cnt - CNT_W'(1);
      if (cnt == '0) begin
        busy     <= 1'b0;
        permille <= PM_W'({quot[Q_W-2:0], ge});
      end
    end
  end

  assign stat.busy     = busy;
  assign stat.permille = permille;

endmodule

>>> rtl/psl_filter.sv
// Merge stage: gas minus brake through a Q0.16 first-order low-pass, clamped.
module psl_filter
  import psl_pkg::*;
#(
  parameter int unsigned FILTER_COEFF_Q16 = 63155
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [PM_W-1:0] gas_pm,
  input  logic [PM_W-1:0] brake_pm,
  output logic            done,
  output logic [PM_W-1:0] value
);

  localparam logic signed [16:0] COEFF_EXT = 17'(FILTER_COEFF_Q16);

  logic                   mul_vld;
  logic signed [28:0]     prod_q;
  logic signed [PM_W:0]   diff_q;
  logic [PM_W-1:0]        fv;

  logic signed [PM_W:0]   diff;
  logic signed [PM_W+1:0] delta;
  logic signed [28:0]     prod;
  logic signed [29:0]     acc;
  logic [PM_W-1:0]        fv_next;

  // a*fv + (1-a)*d is computed as a*(fv - d) + d, one multiply
  assign diff  = $signed({1'b0, gas_pm}) - $signed({1'b0, brake_pm});
  assign delta = $signed({2'b00, fv}) - $signed({diff[PM_W], diff});
  assign prod  = COEFF_EXT * delta;
  assign acc   = $signed({prod_q[28], prod_q})
               + $signed({{3{diff_q[PM_W]}}, diff_q, 16'b0});

  // Negative accumulator truncates to a quotient of zero or below: clamp to 0
  always_comb begin
    if (acc[29]) begin
      fv_next = '0;
    end else if (acc[28:16] > 13'(FULL_SCALE)) begin
      fv_next = FULL_SCALE;
    end else begin
      fv_next = acc[16 +: PM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
      done    <= 1'b0;
      fv      <= '0;
    end else begin
      mul_vld <= start;
      done    <= mul_vld;
      if (mul_vld) begin
        fv <= fv_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_q <= prod;
      diff_q <= diff;
    end
  end

  assign value = fv;

endmodule

>>> tb/sv/pedal_scale_and_lowpass_tb.sv
// Self-checking testbench for the pedal scale and low-pass block.
module pedal_scale_and_lowpass_tb;
  import psl_pkg::*;

  localparam int unsigned LPF_COEFF_Q16 = 63155;
  localparam int MV_TOP        = (1 << MV_W) - 1;
  localparam int SETTLE_CYCLES = 24;    // longer than one item takes from acceptance to result
  localparam int IDLE_LIMIT    = 4000;  // cycles without any handshake before giving up
  localparam int FIRST_RANDOM  = 200;
  localparam int PHASE_WORDS   = 90;

  // Calibration shapes applied to each min/max register pair.
  typedef enum int {
    CAL_RESET, CAL_FULL, CAL_ZERO_SPAN, CAL_INVERTED, CAL_NARROW, CAL_SPREAD, CAL_MIXED
  } cal_kind_e;

  // Output-side back-pressure patterns.
  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_BURSTY} sink_mode_e;

  localparam int NUM_PHASES = 7;
  localparam cal_kind_e CAL_PLAN [NUM_PHASES] = '{
    CAL_FULL, CAL_ZERO_SPAN, CAL_INVERTED, CAL_NARROW, CAL_SPREAD, CAL_MIXED, CAL_RESET
  };

  // Ports: every input starts at a known value.
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  psl_in_t              in_word   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  psl_out_t             out_word;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GAS_FRONT_MIN;
  logic [MV_W-1:0]      cfg_wdata = '0;

  // Predictor state: its own copy of the calibration and of the filter.
  logic [MV_W-1:0] cal_mv [NUM_CFG];
  logic [PM_W-1:0] filter_state = '0;

  psl_in_t  pending_words [$];     // words waiting for the driver
  psl_out_t expected_results [$];  // predictions for accepted words, oldest first

  int         mismatches    = 0;
  int         words_taken   = 0;
  int         results_seen  = 0;
  int         settings_used = 0;
  int         idle_cycles   = 0;
  bit         word_taken    = 1'b0;
  int         burst_left    = 0;
  int         gap_left      = 0;
  int         stall_left    = 0;
  sink_mode_e sink_mode     = SINK_OPEN;

  pedal_scale_and_lowpass #(
    .FILTER_COEFF_Q16(LPF_COEFF_Q16)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Map a voltage onto per mille of its span. The over-max test comes first, so an
  // inverted calibration gives full scale above max and zero everywhere else.
  function automatic int scale_to_permille(input logic [MV_W-1:0] v,
                                           input logic [MV_W-1:0] lo,
                                           input logic [MV_W-1:0] hi);
    if (v > hi) return 1000;
    if (v < lo) return 0;
    if (hi == lo) return 0;
    return (1000 * (int'(v) - int'(lo))) / (int'(hi) - int'(lo));
  endfunction

  // Advance the filter by one word and return the result word it should produce.
  function automatic psl_out_t advance_filter(input psl_in_t w);
    int       gas;
    int       brake;
    longint   acc;
    longint   q;
    psl_out_t r;
    if (w.seat_is_front) begin
      gas   = scale_to_permille(w.gas_front_mv, cal_mv[REG_GAS_FRONT_MIN],
                                cal_mv[REG_GAS_FRONT_MAX]);
      brake = scale_to_permille(w.brake_front_mv, cal_mv[REG_BRAKE_FRONT_MIN],
                                cal_mv[REG_BRAKE_FRONT_MAX]);
    end else begin
      gas   = scale_to_permille(w.gas_rear_mv, cal_mv[REG_GAS_REAR_MIN],
                                cal_mv[REG_GAS_REAR_MAX]);
      brake = scale_to_permille(w.brake_rear_mv, cal_mv[REG_BRAKE_REAR_MIN],
                                cal_mv[REG_BRAKE_REAR_MAX]);
    end
    // Q0.16 blend of old state and new difference; '/' truncates toward zero.
    acc = longint'(LPF_COEFF_Q16) * longint'(filter_state)
        + longint'(65536 - LPF_COEFF_Q16) * longint'(gas - brake);
    q = acc / 65536;
    if (q > 1000) q = 1000;
    if (q < 0) q = 0;
    filter_state     = q[PM_W-1:0];
    r.filtered_pedal = filter_state;
    r.brake_permille = brake[PM_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // Monitor: sample at the rising edge, check results, predict accepted words.
  always @(posedge clk) begin : watch_ports
    psl_out_t want;
    word_taken = 1'b0;
    if (!rst) begin
      // Check the result first: it belongs to a word taken on an earlier edge.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d with nothing pending",
                                    out_word.filtered_pedal, out_word.brake_permille));
        end else begin
          want = expected_results.pop_front();
          if (out_word.filtered_pedal !== want.filtered_pedal)
            report_mismatch($sformatf("result %0d filtered_pedal got %0d want %0d",
                                      results_seen, out_word.filtered_pedal,
                                      want.filtered_pedal));
          if (out_word.brake_permille !== want.brake_permille)
            report_mismatch($sformatf("result %0d brake_permille got %0d want %0d",
                                      results_seen, out_word.brake_permille,
                                      want.brake_permille));
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(advance_filter(in_word));
        words_taken++;
        word_taken = 1'b1;
      end
      // Watchdog: any handshake on either side counts as progress.
      if ((out_valid && out_ready) || word_taken) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results still pending",
                 idle_cycles, expected_results.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // Driver: advance on the falling edge. Hold the word until taken, then send in
  // bursts of random length separated by random gaps (sometimes none at all).
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_word  <= pending_words.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall according to the pattern of the current phase.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      case (sink_mode)
        SINK_OPEN: begin
          out_ready <= 1'b1;
        end
        SINK_RANDOM: begin
          out_ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 24);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Write one calibration register and track it in the predictor. Only called
  // while the block is idle, so the copy may change ahead of the write edge.
  task automatic write_cal(input cfg_reg_e idx, input int value);
    @(negedge clk);
    cfg_we      <= 1'b1;
    cfg_index   <= idx;
    cfg_wdata   <= value[MV_W-1:0];
    cal_mv[idx] = value[MV_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_span(input cfg_reg_e lo_reg, input cfg_reg_e hi_reg,
                          input cal_kind_e kind);
    int        lo;
    int        hi;
    cal_kind_e k;
    k = kind;
    if (k == CAL_MIXED) k = cal_kind_e'($urandom_range(CAL_FULL, CAL_SPREAD));
    case (k)
      CAL_RESET: begin
        lo = CFG_RESET[lo_reg];
        hi = CFG_RESET[hi_reg];
      end
      CAL_FULL: begin
        lo = 0;
        hi = MV_TOP;
      end
      CAL_ZERO_SPAN: begin
        case ($urandom_range(0, 3))
          0:       lo = 0;
          1:       lo = MV_TOP;
          default: lo = $urandom_range(0, 5000);
        endcase
        hi = lo;
      end
      CAL_INVERTED: begin
        lo = $urandom_range(1, 5000);
        hi = $urandom_range(0, lo - 1);
      end
      CAL_NARROW: begin
        lo = $urandom_range(0, 5000);
        hi = lo + $urandom_range(1, 3);
      end
      default: begin
        lo = $urandom_range(0, 5000);
        hi = $urandom_range(lo, 5000);
      end
    endcase
    write_cal(lo_reg, lo);
    write_cal(hi_reg, hi);
  endtask

  task automatic program_cal(input cal_kind_e kind);
    set_span(REG_GAS_FRONT_MIN, REG_GAS_FRONT_MAX, kind);
    set_span(REG_GAS_REAR_MIN, REG_GAS_REAR_MAX, kind);
    set_span(REG_BRAKE_FRONT_MIN, REG_BRAKE_FRONT_MAX, kind);
    set_span(REG_BRAKE_REAR_MIN, REG_BRAKE_REAR_MAX, kind);
    settings_used++;
  endtask

  // Pick a voltage around a calibrated span: its edges, one past them, inside it,
  // or anywhere in the 13-bit field.
  function automatic int pick_mv(input int lo, input int hi);
    int a;
    int b;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, MV_TOP);
      1:       return lo;
      2:       return hi;
      3:       return (lo > 0) ? lo - 1 : 0;
      4:       return (hi < MV_TOP) ? hi + 1 : MV_TOP;
      5:       return $urandom_range(0, 5000);
      default: return $urandom_range(b, a);
    endcase
  endfunction

  function automatic int jitter(input int v);
    int r;
    r = v + int'($urandom_range(0, 6)) - 3;
    if (r < 0) r = 0;
    if (r > MV_TOP) r = MV_TOP;
    return r;
  endfunction

  function automatic psl_in_t make_word(input int gf, input int gr, input int bf,
                                        input int br, input bit front);
    psl_in_t w;
    w.gas_front_mv   = gf[MV_W-1:0];
    w.gas_rear_mv    = gr[MV_W-1:0];
    w.brake_front_mv = bf[MV_W-1:0];
    w.brake_rear_mv  = br[MV_W-1:0];
    w.seat_is_front  = front;
    return w;
  endfunction

  // Directed words for the reset calibration: field extremes, span edges, one past
  // the edges, a sustained gas press and a brake press that pulls the filter down.
  task automatic queue_directed();
    int gf_lo;
    int gr_lo;
    int bf_lo;
    int br_lo;
    int gf_hi;
    int gr_hi;
    int bf_hi;
    int br_hi;
    gf_lo = cal_mv[REG_GAS_FRONT_MIN];
    gr_lo = cal_mv[REG_GAS_REAR_MIN];
    bf_lo = cal_mv[REG_BRAKE_FRONT_MIN];
    br_lo = cal_mv[REG_BRAKE_REAR_MIN];
    gf_hi = cal_mv[REG_GAS_FRONT_MAX];
    gr_hi = cal_mv[REG_GAS_REAR_MAX];
    bf_hi = cal_mv[REG_BRAKE_FRONT_MAX];
    br_hi = cal_mv[REG_BRAKE_REAR_MAX];
    for (int s = 0; s < 2; s++) begin
      pending_words.push_back(make_word(0, 0, 0, 0, s[0]));
      pending_words.push_back(make_word(MV_TOP, MV_TOP, MV_TOP, MV_TOP, s[0]));
      pending_words.push_back(make_word(gf_lo, gr_lo, bf_lo, br_lo, s[0]));
      pending_words.push_back(make_word(gf_hi, gr_hi, bf_hi, br_hi, s[0]));
      pending_words.push_back(make_word(gf_lo - 1, gr_lo - 1, bf_lo - 1, br_lo - 1, s[0]));
      pending_words.push_back(make_word(gf_hi + 1, gr_hi + 1, bf_hi + 1, br_hi + 1, s[0]));
      pending_words.push_back(make_word('h0AAA, 'h1555, 'h1555, 'h0AAA, s[0]));
    end
    repeat (6) pending_words.push_back(make_word(gf_hi, gr_hi, bf_lo, br_lo, 1'b1));
    pending_words.push_back(make_word(2500, 2500, 2500, 2500, 1'b0));
    repeat (2) pending_words.push_back(make_word(gf_lo, gr_lo, bf_hi, br_hi, 1'b0));
  endtask

  // Random words: mostly held pedal positions with a little jitter, so the filter
  // settles toward real targets, mixed with single words of raw noise.
  task automatic queue_random(input int count);
    int made;
    int run;
    int gf;
    int gr;
    int bf;
    int br;
    bit front;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 4) == 0) begin
        pending_words.push_back(make_word($urandom_range(0, MV_TOP), $urandom_range(0, MV_TOP),
                                          $urandom_range(0, MV_TOP), $urandom_range(0, MV_TOP),
                                          1'($urandom_range(0, 1))));
        made++;
      end else begin
        run   = $urandom_range(1, 40);
        front = 1'($urandom_range(0, 1));
        gf    = pick_mv(cal_mv[REG_GAS_FRONT_MIN], cal_mv[REG_GAS_FRONT_MAX]);
        gr    = pick_mv(cal_mv[REG_GAS_REAR_MIN], cal_mv[REG_GAS_REAR_MAX]);
        bf    = pick_mv(cal_mv[REG_BRAKE_FRONT_MIN], cal_mv[REG_BRAKE_FRONT_MAX]);
        br    = pick_mv(cal_mv[REG_BRAKE_REAR_MIN], cal_mv[REG_BRAKE_REAR_MAX]);
        if (run > count - made) run = count - made;
        repeat (run) begin
          pending_words.push_back(make_word(jitter(gf), jitter(gr), jitter(bf), jitter(br),
                                            front));
        end
        made += run;
      end
    end
  endtask

  // Hold off until every word is sent and every result has come back, then let
  // the block settle. This is also the full drain before each calibration change.
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : run_phases
    for (int i = 0; i < NUM_CFG; i++) cal_mv[i] = CFG_RESET[i];
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset calibration first, written back explicitly, with the directed words.
    program_cal(CAL_RESET);
    sink_mode = SINK_OPEN;
    queue_directed();
    queue_random(FIRST_RANDOM);
    wait_idle();

    // Then one phase per calibration shape, each with a back-pressure pattern cycling through the sink modes.
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_cal(CAL_PLAN[p]);
      sink_mode = sink_mode_e'(p % 3);
      queue_random(PHASE_WORDS);
      wait_idle();
    end

    $display("covered %0d words, %0d results, %0d calibration settings, %0d mismatches",
             words_taken, results_seen, settings_used, mismatches);
    $display("calibrations: reset, full range, zero span, inverted, narrow, spread, mixed");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
